// ===== hw/rtl/lsbc_pkg.sv =====
package lsbc_pkg;

  localparam int unsigned NUM_SAMPLES = 64;
  localparam int unsigned BUFFERS     = 5;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 16;

  localparam int unsigned ADDR_W  = $clog2(NUM_SAMPLES);
  localparam int unsigned CNT_W   = $clog2(NUM_SAMPLES + 1);

  typedef struct packed {
    logic [IDX_W-1:0]  evicted_sample;
    logic              evicted_valid;
    logic              load_needed;
    logic [SLOT_W-1:0] play_slot;
    logic              play_valid;
    logic              accepted;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  typedef struct packed {
    logic load_req;
    logic decide;
    logic scan;
    logic victim_wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_evict;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/lsbc_ctrl.sv =====
module lsbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lsbc_pkg::sts_t sts_i,
  output lsbc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_VICTIM_RD,
    ST_VICTIM_WB,
    ST_FINISH
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state_q <= sts_i.need_evict ? ST_SCAN : ST_FINISH;
        end
        ST_SCAN: begin
          if (sts_i.scan_done) state_q <= ST_VICTIM_RD;
        end
        ST_VICTIM_RD: state_q <= ST_VICTIM_WB;
        ST_VICTIM_WB: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign cmd_o.load_req   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.decide     = (state_q == ST_DECIDE);
  assign cmd_o.scan       = (state_q == ST_SCAN);
  assign cmd_o.victim_wb  = (state_q == ST_VICTIM_WB);
  assign cmd_o.out_load   = (state_q == ST_FINISH) && sts_i.out_free;

endmodule

// ===== hw/rtl/lsbc_datapath.sv =====
module lsbc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic [lsbc_pkg::IN_W-1:0]   in_data_i,
  input  lsbc_pkg::cmd_t              cmd_i,
  output lsbc_pkg::sts_t              sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lsbc_pkg::OUT_W-1:0]  out_data_o
);

  localparam int unsigned AW   = lsbc_pkg::ADDR_W;
  localparam int unsigned CW   = lsbc_pkg::CNT_W;
  localparam int unsigned NS   = lsbc_pkg::NUM_SAMPLES;
  localparam int unsigned SW   = lsbc_pkg::SLOT_W;
  localparam int unsigned TW   = lsbc_pkg::STAMP_W;
  localparam int unsigned IW   = lsbc_pkg::IDX_W;
  localparam int unsigned PW   = lsbc_pkg::PRI_W;

  logic [IW-1:0]        in_idx;
  logic                 in_has;
  logic signed [PW-1:0] in_pri;
  logic                 in_busy;
  logic                 in_acc;
  logic                 in_inr;

  logic                 enable_q;
  logic signed [PW-1:0] last_pri_q;
  logic [TW-1:0]        counter_q;
  logic [CW-1:0]        count_q;
  logic [NS-1:0]        resident_q;

  logic [AW-1:0]        req_idx_q;
  logic                 req_has_q;
  logic                 req_inr_q;
  logic                 acc_q;

  logic [SW-1:0]        slot_mem [NS];
  logic [TW-1:0]        stamp_mem [NS];
  logic [SW-1:0]        slot_rd_q;
  logic [TW-1:0]        stamp_rd_q;
  logic [AW-1:0]        slot_raddr;

  logic [CW-1:0]        scan_addr_q;
  logic                 scan_vld_q;
  logic [AW-1:0]        scan_ad_q;
  logic [TW-1:0]        best_q;
  logic                 found_q;
  logic [AW-1:0]        victim_q;

  logic                 hit;
  logic                 place;
  logic                 evict;
  logic                 quick_play;
  logic                 slot_we;
  logic [SW-1:0]        slot_wdata;
  logic                 stamp_we;
  logic                 better;

  lsbc_pkg::res_t       res_q;
  lsbc_pkg::res_t       out_q;
  logic                 out_valid_q;

  assign in_idx  = in_data_i[IW-1:0];
  assign in_has  = in_data_i[IW];
  assign in_pri  = signed'(in_data_i[IW+PW:IW+1]);
  assign in_busy = in_data_i[IW+PW+1];
  assign in_acc  = enable_q && (!in_busy || (in_pri >= last_pri_q));
  assign in_inr  = (32'(in_idx) < 32'(NS));

  assign hit        = resident_q[req_idx_q];
  assign place      = acc_q && req_inr_q && req_has_q && !hit;
  assign evict      = place && (count_q >= CW'(lsbc_pkg::BUFFERS - 1));
  assign quick_play = acc_q && req_inr_q && (hit || (place && !evict));

  assign slot_we    = (cmd_i.decide && place && !evict) || cmd_i.victim_wb;
  assign slot_wdata = cmd_i.victim_wb ? slot_rd_q : count_q[SW-1:0];
  assign stamp_we   = (cmd_i.decide && quick_play) || cmd_i.victim_wb;
  assign slot_raddr = cmd_i.load_req ? AW'(in_idx) : victim_q;
  assign better     = scan_vld_q && resident_q[scan_ad_q] && (!found_q || (stamp_rd_q < best_q));

  assign sts_o.need_evict = evict;
  assign sts_o.scan_done  = (scan_addr_q == CW'(NS)) && !scan_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[req_idx_q] <= slot_wdata;
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) stamp_mem[req_idx_q] <= counter_q;
    stamp_rd_q <= stamp_mem[scan_addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      last_pri_q  <= '0;
      counter_q   <= '0;
      count_q     <= '0;
      resident_q  <= '0;
      acc_q       <= 1'b0;
      scan_addr_q <= '0;
      scan_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) enable_q <= cfg_wdata_i;

      if (cmd_i.load_req) begin
        acc_q <= in_acc;
        if (in_acc) last_pri_q <= in_pri;
      end

      if (cmd_i.decide) begin
        if (place && !evict) begin
          resident_q[req_idx_q] <= 1'b1;
          count_q               <= count_q + CW'(1);
        end
        if (quick_play) counter_q <= counter_q + TW'(1);
        if (evict) begin
          scan_addr_q <= '0;
          scan_vld_q  <= 1'b0;
          found_q     <= 1'b0;
        end
      end

      if (cmd_i.scan) begin
        if (scan_addr_q < CW'(NS)) begin
          scan_addr_q <= scan_addr_q + CW'(1);
          scan_vld_q  <= 1'b1;
        end else begin
          scan_vld_q  <= 1'b0;
        end
        if (better) found_q <= 1'b1;
      end

      if (cmd_i.victim_wb) begin
        resident_q[victim_q]  <= 1'b0;
        resident_q[req_idx_q] <= 1'b1;
        counter_q             <= counter_q + TW'(1);
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_idx_q <= AW'(in_idx);
      req_has_q <= in_has;
      req_inr_q <= in_inr;
    end

    if (cmd_i.scan) begin
      scan_ad_q <= scan_addr_q[AW-1:0];
      if (better) begin
        best_q   <= stamp_rd_q;
        victim_q <= scan_ad_q;
      end
    end

    if (cmd_i.decide) begin
      res_q <= '{evicted_sample: '0,
                 evicted_valid:  1'b0,
                 load_needed:    quick_play && place,
                 play_slot:      !quick_play ? '0 : (hit ? slot_rd_q : count_q[SW-1:0]),
                 play_valid:     quick_play,
                 accepted:       acc_q};
    end

    if (cmd_i.victim_wb) begin
      res_q.accepted       <= 1'b1;
      res_q.play_valid     <= 1'b1;
      res_q.play_slot      <= slot_rd_q;
      res_q.load_needed    <= 1'b1;
      res_q.evicted_valid  <= 1'b1;
      res_q.evicted_sample <= IW'(victim_q);
    end

    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(lsbc_pkg::OUT_W - lsbc_pkg::RES_W){1'b0}}, out_q};

  a_count_matches_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(resident_q) == int'(count_q))
    else $error("resident count out of step with resident flags");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(lsbc_pkg::BUFFERS - 1))
    else $error("more samples resident than free slots allow");

  a_victim_is_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.victim_wb |-> (found_q && resident_q[victim_q] && !resident_q[req_idx_q]))
    else $error("eviction target not a resident sample");

  a_evict_implies_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (!out_q.evicted_valid || (out_q.load_needed && out_q.play_valid)))
    else $error("eviction reported without a load");

endmodule

// ===== hw/rtl/lru_sample_buffer_cache.sv =====
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: sample_index, has_data, priority_req, voice_busy
// m_axis    out  tvalid/tready           tdata: accepted, play_valid, play_slot, load_needed,
//                                               evicted_valid, evicted_sample
// cfg       in   cfg_we_i                cfg_wdata_i: enable
//
// One request at a time. A request that needs no eviction passes through the decide and finish
// states; one that evicts also passes through scan, victim read and victim writeback, its length
// set by the scan of the use-stamp memory, one entry per cycle through its single read port.
// The result register lets the next request transfer in while a result waits; a
// stalled output holds the block in its final state until the result is taken.
// Reset clears the resident flags, counters and last priority at once; no clearing pass.
module lru_sample_buffer_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [5:0] sample_index, [6] has_data, [14:7] priority_req, [15] voice_busy
  input  logic [lsbc_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [0] accepted, [1] play_valid, [3:2] play_slot, [4] load_needed,
  // [5] evicted_valid, [11:6] evicted_sample, [15:12] zero
  output logic [lsbc_pkg::OUT_W-1:0] m_axis_tdata_o
);

  lsbc_pkg::cmd_t cmd;
  lsbc_pkg::sts_t sts;

  lsbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
